// File: hdl/rgbfx_pkg.sv
// Package for the RGB LED effect engine: colour type, effect modes, command
// codes, register indexes and reset values. No dependencies.
package rgbfx_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = PERIOD_W;

    localparam logic [CHAN_W-1:0]   CHAN_MAX       = 8'd255;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd1000;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHASE          = 2'd0,
        MODE_RAINBOW_EQUAL  = 2'd1,
        MODE_RAINBOW_OFFSET = 2'd2,
        MODE_RAINBOW_TOP    = 2'd3
    } mode_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EFFECT_MODE = 1'b0,
        CFG_STEP_PERIOD = 1'b1
    } cfg_idx_t;

endpackage

// File: hdl/rgbfx_if.sv
// Valid/ready channel interfaces of the RGB LED effect engine: the command
// channel and the LED colour channel. Depends on rgbfx_pkg.
interface rgbfx_cmd_if;
    import rgbfx_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    chan_t load_red;
    chan_t load_green;
    chan_t load_blue;

    modport source (output valid, op, load_red, load_green, load_blue, input ready);
    modport sink   (input valid, op, load_red, load_green, load_blue, output ready);
endinterface

interface rgbfx_led_if;
    import rgbfx_pkg::*;

    logic  valid;
    logic  ready;
    chan_t first_red;
    chan_t first_green;
    chan_t first_blue;
    chan_t second_red;
    chan_t second_green;
    chan_t second_blue;
    chan_t third_red;
    chan_t third_green;
    chan_t third_blue;

    modport source (
        output valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
               third_red, third_green, third_blue,
        input  ready
    );
    modport sink (
        input  valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
               third_red, third_green, third_blue,
        output ready
    );
endinterface

// File: hdl/rgb_led_effect_engine.sv
// Top level of the RGB LED effect engine for three LEDs.
// Depends on rgbfx_pkg and the channel interfaces in rgbfx_if.sv.
//
// Each command transaction (a time tick or a colour load) produces exactly one
// registered LED transaction carrying all three LED colours. A command
// is accepted every cycle while the output register is empty or being drained,
// so the sustained rate is one transaction per clock; the only limit is the
// single output register, which stalls the command side while the LED side
// holds ready low. Configuration writes take effect on the next command.
module rgb_led_effect_engine (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [rgbfx_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rgbfx_pkg::CFG_DATA_W-1:0]       cfg_data,
    rgbfx_cmd_if.sink                              cmd,
    rgbfx_led_if.source                            led
);
    import rgbfx_pkg::*;

    mode_t                mode_reg;
    logic [PERIOD_W-1:0]  period_reg;
    color_t               lead_reg, lead_next;
    color_t               goal_reg, goal_next;
    color_t               second_reg, second_next;
    color_t               third_reg, third_next;
    logic [PERIOD_W-1:0]  div_reg, div_next, div_inc;
    logic                 out_valid_reg;
    color_t               out_first_reg, out_second_reg, out_third_reg;

    logic                 accept;
    logic                 step_hit;
    color_t               rotated;
    color_t               moved;

    assign cmd.ready = !out_valid_reg || led.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RAINBOW_EQUAL;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EFFECT_MODE: mode_reg   <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_STEP_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default:         ;
            endcase
        end
    end

    assign rotated  = '{red: lead_reg.green, green: lead_reg.blue, blue: lead_reg.red};
    assign div_inc  = div_reg + 1'b1;
    assign step_hit = (div_inc == period_reg);

    always_comb
    begin
        moved = lead_reg;
        if (goal_reg.red > lead_reg.red)
            moved.red = lead_reg.red + 1'b1;
        else if (goal_reg.red < lead_reg.red)
            moved.red = lead_reg.red - 1'b1;
        if (goal_reg.green > lead_reg.green)
            moved.green = lead_reg.green + 1'b1;
        else if (goal_reg.green < lead_reg.green)
            moved.green = lead_reg.green - 1'b1;
        if (goal_reg.blue > lead_reg.blue)
            moved.blue = lead_reg.blue + 1'b1;
        else if (goal_reg.blue < lead_reg.blue)
            moved.blue = lead_reg.blue - 1'b1;
    end

    always_comb
    begin
        lead_next   = lead_reg;
        goal_next   = goal_reg;
        second_next = second_reg;
        third_next  = third_reg;
        div_next    = div_reg;
        if (op_t'(cmd.op) == OP_LOAD)
        begin
            lead_next = '{red: cmd.load_red, green: cmd.load_green, blue: cmd.load_blue};
            goal_next = lead_next;
        end
        else
        begin
            case (mode_reg)
                MODE_RAINBOW_EQUAL:
                begin
                    second_next = lead_reg;
                    third_next  = lead_reg;
                end
                MODE_RAINBOW_TOP:
                begin
                    second_next = rotated;
                    third_next  = rotated;
                end
                default:
                begin
                    second_next = rotated;
                    third_next  = '{red: lead_reg.blue, green: lead_reg.red,
                                    blue: lead_reg.green};
                end
            endcase
            div_next = div_inc;
            if (step_hit)
            begin
                div_next = '0;
                if (mode_reg == MODE_CHASE)
                    lead_next = rotated;
                else
                begin
                    lead_next = moved;
                    // The six hue-wheel corners are mutually exclusive.
                    if (moved == color_t'{CHAN_MAX, '0, '0})
                        goal_next.green = CHAN_MAX;
                    if (moved == color_t'{CHAN_MAX, CHAN_MAX, '0})
                        goal_next.red = '0;
                    if (moved == color_t'{'0, CHAN_MAX, '0})
                        goal_next.blue = CHAN_MAX;
                    if (moved == color_t'{'0, CHAN_MAX, CHAN_MAX})
                        goal_next.green = '0;
                    if (moved == color_t'{'0, '0, CHAN_MAX})
                        goal_next.red = CHAN_MAX;
                    if (moved == color_t'{CHAN_MAX, '0, CHAN_MAX})
                        goal_next.blue = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= '0;
            goal_reg      <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            div_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lead_reg   <= lead_next;
                goal_reg   <= goal_next;
                second_reg <= second_next;
                third_reg  <= third_next;
                div_reg    <= div_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (led.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_first_reg  <= lead_next;
            out_second_reg <= second_next;
            out_third_reg  <= third_next;
        end
    end

    assign led.valid        = out_valid_reg;
    assign led.first_red    = out_first_reg.red;
    assign led.first_green  = out_first_reg.green;
    assign led.first_blue   = out_first_reg.blue;
    assign led.second_red   = out_second_reg.red;
    assign led.second_green = out_second_reg.green;
    assign led.second_blue  = out_second_reg.blue;
    assign led.third_red    = out_third_reg.red;
    assign led.third_green  = out_third_reg.green;
    assign led.third_blue   = out_third_reg.blue;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the RGB LED effect engine: drives command transactions and register
// writes, predicts every LED transaction and checks it field by field.
// Depends on rgbfx_pkg, the channel interfaces in rgbfx_if.sv and the engine top level.
module tb_top;
    import rgbfx_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        color_t first;
        color_t second;
        color_t third;
    } leds_t;

    class led_scoreboard;
        mode_t               mode;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] divider;
        color_t              lead;
        color_t              goal;
        color_t              second;
        color_t              third;
        leds_t               expected_leds[$];
        string               field_names[9];
        bit [3:0]            modes_seen;
        int                  errors;
        int                  checked;
        int                  loads;
        int                  ticks;
        int                  steps;

        function new();
            mode        = MODE_RAINBOW_EQUAL;
            period      = PERIOD_RESET;
            divider     = '0;
            lead        = '0;
            goal        = '0;
            second      = '0;
            third       = '0;
            modes_seen  = '0;
            errors      = 0;
            checked     = 0;
            loads       = 0;
            ticks       = 0;
            steps       = 0;
            field_names = '{"first_red", "first_green", "first_blue",
                            "second_red", "second_green", "second_blue",
                            "third_red", "third_green", "third_blue"};
        endfunction

        function void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_EFFECT_MODE)
                mode = mode_t'(data[MODE_W-1:0]);
            else
                period = data[PERIOD_W-1:0];
        endfunction

        function color_t rotate(color_t c);
            return {c.green, c.blue, c.red};
        endfunction

        function chan_t approach(chan_t c, chan_t g);
            if (g > c)
                return c + 8'd1;
            if (g < c)
                return c - 8'd1;
            return c;
        endfunction

        function void rainbow_step();
            lead.red   = approach(lead.red, goal.red);
            lead.green = approach(lead.green, goal.green);
            lead.blue  = approach(lead.blue, goal.blue);
            if (lead == {CHAN_MAX, 8'h00, 8'h00})
                goal.green = CHAN_MAX;
            if (lead == {CHAN_MAX, CHAN_MAX, 8'h00})
                goal.red = 8'h00;
            if (lead == {8'h00, CHAN_MAX, 8'h00})
                goal.blue = CHAN_MAX;
            if (lead == {8'h00, CHAN_MAX, CHAN_MAX})
                goal.green = 8'h00;
            if (lead == {8'h00, 8'h00, CHAN_MAX})
                goal.red = CHAN_MAX;
            if (lead == {CHAN_MAX, 8'h00, CHAN_MAX})
                goal.blue = 8'h00;
        endfunction

        // The followers always take the lead colour from before this tick's step.
        function void tick();
            color_t start;
            start = lead;
            ticks++;
            modes_seen[mode] = 1'b1;
            case (mode)
                MODE_RAINBOW_EQUAL:
                begin
                    second = start;
                    third  = start;
                end
                MODE_RAINBOW_TOP:
                begin
                    second = rotate(start);
                    third  = rotate(start);
                end
                default:
                begin
                    second = rotate(start);
                    third  = rotate(rotate(start));
                end
            endcase
            divider = divider + 1'b1;
            if (divider == period)
            begin
                divider = '0;
                steps++;
                if (mode == MODE_CHASE)
                    lead = rotate(start);
                else
                    rainbow_step();
            end
        endfunction

        function void note_command(op_t op, color_t load);
            if (op == OP_LOAD)
            begin
                lead = load;
                goal = load;
                loads++;
            end
            else
                tick();
            expected_leds.push_back({lead, second, third});
        endfunction

        function void flag(string what, int want_v, int got_v);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%t: mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
        endfunction

        function void check_leds(leds_t got);
            leds_t want;
            if (expected_leds.size() == 0)
            begin
                flag("LED transaction with nothing pending", 0, 1);
                return;
            end
            want = expected_leds.pop_front();
            checked++;
            for (int i = 0; i < 9; i++)
            begin
                if (want[71-8*i -: 8] !== got[71-8*i -: 8])
                    flag(field_names[i], int'(want[71-8*i -: 8]), int'(got[71-8*i -: 8]));
            end
        endfunction

        function int pending();
            return expected_leds.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_req;
    bit                    hold_served;
    int                    burst_left;
    int                    idle_cycles;
    led_scoreboard         sb;

    rgbfx_cmd_if cmd_ch ();
    rgbfx_led_if led_ch ();

    rgb_led_effect_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .led       (led_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (led_ch.valid && led_ch.ready)
                sb.check_leds({led_ch.first_red, led_ch.first_green, led_ch.first_blue,
                               led_ch.second_red, led_ch.second_green, led_ch.second_blue,
                               led_ch.third_red, led_ch.third_green, led_ch.third_blue});
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(op_t'(cmd_ch.op),
                                {cmd_ch.load_red, cmd_ch.load_green, cmd_ch.load_blue});
            if ((led_ch.valid && led_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("rgb_led_effect_engine test failed");
                $finish;
            end
        end
    end

    // The LED side switches between stall patterns; one long hold-off on request.
    initial
    begin : led_sink
        int style;
        int span;
        int slot;
        style = 0;
        span  = 0;
        slot  = 0;
        led_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            slot++;
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                led_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    style = $urandom_range(0, 3);
                    span  = $urandom_range(16, 128);
                end
                span--;
                case (style)
                    0: led_ch.ready <= 1'b1;
                    1: led_ch.ready <= (slot % 4) != 3;
                    2: led_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: led_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic color_t any_color();
        return 24'($urandom());
    endfunction

    function automatic color_t hue_corner(int k);
        case (k)
            0: return {CHAN_MAX, 8'h00, 8'h00};
            1: return {CHAN_MAX, CHAN_MAX, 8'h00};
            2: return {8'h00, CHAN_MAX, 8'h00};
            3: return {8'h00, CHAN_MAX, CHAN_MAX};
            4: return {8'h00, 8'h00, CHAN_MAX};
            default: return {CHAN_MAX, 8'h00, CHAN_MAX};
        endcase
    endfunction

    task automatic issue(input op_t op, input color_t load);
        int gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.load_red   <= load.red;
        cmd_ch.load_green <= load.green;
        cmd_ch.load_blue  <= load.blue;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 2);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic run_ticks(input int n);
        repeat (n) issue(OP_TICK, any_color());
    endtask

    task automatic run_mix(input int n, input int load_pct);
        color_t c;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < load_pct)
            begin
                if ($urandom_range(0, 2) != 0)
                    c = hue_corner($urandom_range(0, 5));
                else
                    c = any_color();
                issue(OP_LOAD, c);
            end
            else
                issue(OP_TICK, any_color());
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.apply_reg(idx, data);
    endtask

    task automatic set_regs(input mode_t m, input logic [PERIOD_W-1:0] p);
        drain();
        write_reg(CFG_EFFECT_MODE, CFG_DATA_W'(m));
        write_reg(CFG_STEP_PERIOD, p);
    endtask

    initial
    begin
        logic [PERIOD_W-1:0] period;
        int                  pick;
        sb          = new();
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        burst_left  = 0;
        idle_cycles = 0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_TICK;
        cmd_ch.load_red   = '0;
        cmd_ch.load_green = '0;
        cmd_ch.load_blue  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration, then each mode in turn starting from the hue-wheel corners.
        issue(OP_LOAD, hue_corner(0));
        issue(OP_TICK, 24'hFFFFFF);
        set_regs(MODE_CHASE, 16'd2);
        run_ticks(3);
        issue(OP_LOAD, 24'h000000);
        set_regs(MODE_RAINBOW_EQUAL, 16'd1);
        issue(OP_LOAD, hue_corner(0));
        run_ticks(2);
        set_regs(MODE_RAINBOW_OFFSET, 16'd2);
        issue(OP_LOAD, hue_corner(1));
        run_ticks(4);
        set_regs(MODE_RAINBOW_TOP, 16'd1);
        for (int k = 2; k < 6; k++)
        begin
            issue(OP_LOAD, hue_corner(k));
            issue(OP_TICK, any_color());
        end
        issue(OP_LOAD, 24'hFFFFFF);
        issue(OP_TICK, 24'h000000);

        // A long sweep along the hue wheel from red past yellow and green, with a mode change half way.
        set_regs(MODE_RAINBOW_EQUAL, 16'd1);
        issue(OP_LOAD, hue_corner(0));
        run_ticks(350);
        set_regs(MODE_RAINBOW_OFFSET, 16'd1);
        run_ticks(350);

        for (int phase = 0; phase < 10; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                period = PERIOD_W'($urandom_range(1, 3));
            else if (pick < 9)
                period = PERIOD_W'($urandom_range(4, 20));
            else
                period = PERIOD_W'($urandom_range(200, 300));
            drain();
            if (period <= sb.divider)
                period = sb.divider + 1'b1;
            set_regs(mode_t'($urandom_range(0, 3)), period);
            if (phase == 0)
            begin
                hold_req <= 1'b1;
                burst_left = 60;
            end
            run_mix($urandom_range(40, 90), 8);
        end

        // Largest period, then a lower period below the running divider so that it
        // runs on past the period, then the zero period whose only match is the wrap.
        set_regs(MODE_RAINBOW_OFFSET, 16'hFFFF);
        issue(OP_LOAD, hue_corner(4));
        run_ticks(40);
        set_regs(MODE_RAINBOW_OFFSET, 16'd10);
        run_ticks(60);
        set_regs(MODE_CHASE, 16'd0);
        issue(OP_LOAD, 24'h0180FE);
        run_ticks(40);

        drain();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag("LED transactions still outstanding", 0, sb.pending());
        $display("Checked %0d LED transactions from %0d loads and %0d ticks, %0d effect steps.",
                 sb.checked, sb.loads, sb.ticks, sb.steps);
        $display("Modes exercised (bit per mode): %b; periods from 1 to 65535 and zero; %0d errors.",
                 sb.modes_seen, sb.errors);
        if (sb.errors == 0)
            $display("rgb_led_effect_engine test passed");
        else
            $display("rgb_led_effect_engine test failed");
        $finish;
    end

endmodule
